>>> rtl/hgpc_pkg.sv
`default_nettype none

package hgpc_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int COL_DEPTH   = (MAX_COLS < 1024) ? MAX_COLS : 1024;
   localparam int COL_W       = $clog2(COL_DEPTH);
   localparam int ROW_LIMIT   = 1024;
   localparam int ROW_W       = $clog2(ROW_LIMIT);
   localparam int VALUE_W     = 16;
   localparam int SUM_W       = 32;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_COL_COUNT = CSR_INDEX_W'(1);

   typedef logic [SUM_W-1:0] sum_type;

   typedef struct packed {
      sum_type sum;
      sum_type count;
   } path_type;

   // A neighbor outside the grid behaves as a sum of zero reached by one path.
   localparam path_type EDGE_PATH = '{sum: '0, count: SUM_W'(1)};

   typedef struct packed {
      logic             row_zero;
      logic             odd_row;
      logic             right_in;
      logic             last_row;
      logic             last_col;
      logic [COL_W-1:0] col;
   } cell_ctrl_type;

   typedef struct packed {
      logic     last_row;
      logic     last_col;
      path_type path;
   } fold_in_type;

   function automatic sum_type sat_add(sum_type a, sum_type b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/hgpc_channels.sv
`default_nettype none

interface hgpc_req_if;
   import hgpc_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] cell_value;
   modport source (output valid, output cell_value, input ready);
   modport sink (input valid, input cell_value, output ready);
endinterface

interface hgpc_rsp_if;
   import hgpc_pkg::*;
   logic    valid;
   logic    ready;
   sum_type best_sum;
   sum_type path_count;
   modport source (output valid, output best_sum, output path_count, input ready);
   modport sink (input valid, input best_sum, input path_count, output ready);
endinterface

`default_nettype wire

>>> rtl/hgpc_row_mem.sv
`default_nettype none

module hgpc_row_mem (
   input  wire logic                      clock,
   input  wire logic                      rd_en,
   input  wire logic [hgpc_pkg::COL_W-1:0] rd_addr_a,
   input  wire logic [hgpc_pkg::COL_W-1:0] rd_addr_b,
   output hgpc_pkg::path_type             rd_data_a,
   output hgpc_pkg::path_type             rd_data_b,
   input  wire logic                      wr_en,
   input  wire logic [hgpc_pkg::COL_W-1:0] wr_addr,
   input  wire hgpc_pkg::path_type        wr_data
);
   import hgpc_pkg::*;

   path_type mem [COL_DEPTH];
   path_type raw_a_ff;
   path_type raw_b_ff;
   path_type byp_data_ff;
   logic     byp_a_ff;
   logic     byp_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_a_ff <= mem[rd_addr_a];
         raw_b_ff <= mem[rd_addr_b];
      end
   end

   // A read in the same cycle as a write to the same entry returns the new data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_a_ff    <= wr_en && (wr_addr == rd_addr_a);
         byp_b_ff    <= wr_en && (wr_addr == rd_addr_b);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data_a = byp_a_ff ? byp_data_ff : raw_a_ff;
   assign rd_data_b = byp_b_ff ? byp_data_ff : raw_b_ff;

endmodule

`default_nettype wire

>>> rtl/hgpc_cell_calc.sv
`default_nettype none

module hgpc_cell_calc (
   input  wire logic [hgpc_pkg::VALUE_W-1:0] value,
   input  wire hgpc_pkg::cell_ctrl_type     ctrl,
   input  wire hgpc_pkg::path_type          above_a,
   input  wire hgpc_pkg::path_type          above_b,
   input  wire hgpc_pkg::path_type          held,
   output hgpc_pkg::path_type               result
);
   import hgpc_pkg::*;

   sum_type  v_ext;
   sum_type  sum_l;
   sum_type  sum_r;
   path_type left;
   path_type right;

   always_comb begin
      v_ext = SUM_W'(value);
      // Odd rows hang below columns c and c+1, even rows below c-1 and c.
      if (ctrl.odd_row) begin
         left  = above_a;
         right = ctrl.right_in ? above_b : EDGE_PATH;
      end else begin
         left  = held;
         right = above_a;
      end
      sum_l = sat_add(left.sum, v_ext);
      sum_r = sat_add(right.sum, v_ext);
      if (ctrl.row_zero) begin
         result = '{sum: v_ext, count: SUM_W'(1)};
      end else if (sum_r == sum_l) begin
         result = '{sum: sum_l, count: sat_add(left.count, right.count)};
      end else if (sum_r > sum_l) begin
         result = '{sum: sum_r, count: right.count};
      end else begin
         result = '{sum: sum_l, count: left.count};
      end
   end

endmodule

`default_nettype wire

>>> rtl/hgpc_best_fold.sv
`default_nettype none

module hgpc_best_fold (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  restart,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire hgpc_pkg::fold_in_type in_data,
   input  wire logic                  rsp_ready,
   output logic                       stall,
   output logic                       rsp_valid,
   output hgpc_pkg::sum_type          best_sum,
   output hgpc_pkg::sum_type          path_count
);
   import hgpc_pkg::*;

   logic        f_valid_ff;
   fold_in_type f_data_ff;
   sum_type     best_ff;
   sum_type     best_in;
   sum_type     count_ff;
   sum_type     count_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   path_type    result_ff;
   path_type    result_in;
   logic        done;

   always_comb begin
      best_in      = best_ff;
      count_in     = count_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      done         = f_valid_ff && f_data_ff.last_row && f_data_ff.last_col;
      if (advance && f_valid_ff && f_data_ff.last_row) begin
         if (f_data_ff.path.sum > best_ff) begin
            best_in  = f_data_ff.path.sum;
            count_in = f_data_ff.path.count;
         end else if (f_data_ff.path.sum == best_ff) begin
            count_in = sat_add(count_ff, f_data_ff.path.count);
         end
         if (f_data_ff.last_col) begin
            result_in    = '{sum: best_in, count: count_in};
            rsp_valid_in = 1'b1;
            best_in      = '0;
            count_in     = '0;
         end
      end
      if (restart) begin
         best_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff   <= 1'b0;
         best_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            f_valid_ff <= in_valid;
         end
         best_ff      <= best_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_data_ff <= in_data;
      end
      result_ff <= result_in;
   end

   assign stall      = done && rsp_valid_ff && !rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign best_sum   = result_ff.sum;
   assign path_count = result_ff.count;

endmodule

`default_nettype wire

>>> rtl/hex_grid_max_path_counter_top.sv
// Honeycomb grid best-path counter.
// The req_bus channel carries one grid cell per request, in row-major order. A grid
// is row_count rows of col_count cells; the csr_ port sets both sizes, and any write
// to either register restarts the grid at row 0, column 0.
// After the last cell of a grid the rsp_bus channel carries one request with the
// largest last-row path sum and the number of paths reaching it, both saturating.
// The grid takes one cell per clock while the pipeline is not stalled. A cell passes an
// input stage (row memory read), a cell stage (path arithmetic and row memory write)
// and a fold stage (running last-row maximum); the result is then registered.
// The row memory has one write and two read ports; the cell just computed is
// bypassed to a read of the same column in the same cycle.
// Reset sets both sizes to one and clears all control state. The row memory is not
// cleared: row 0 of each grid writes every column before any row reads it.
// The result is held in an output register. While it waits, cells keep flowing;
// only when the next grid's last cell reaches the fold stage with the register
// still full does the pipeline stop and req_bus.ready drop until rsp_bus.ready.
`default_nettype none

module hex_grid_max_path_counter_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   hgpc_req_if.sink                            req_bus,
   hgpc_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_write_en,
   input  wire logic [hgpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hgpc_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import hgpc_pkg::*;

   logic               advance;
   logic               stall;
   logic               accept;
   logic               restart;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic [ROW_W-1:0]   last_row_ff;
   logic [ROW_W-1:0]   last_row_in;
   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [COL_W-1:0]   last_col_ff;
   logic [COL_W-1:0]   last_col_in;
   logic [COL_W-1:0]   addr_b;
   cell_ctrl_type      ctrl_in;
   logic               s2_valid_ff;
   logic [VALUE_W-1:0] s2_value_ff;
   cell_ctrl_type      s2_ctrl_ff;
   path_type           held_ff;
   path_type           held_in;
   path_type           above_a;
   path_type           above_b;
   path_type           cell_result;
   fold_in_type        fold_in;
   logic               rsp_valid;
   sum_type            best_sum;
   sum_type            path_count;

   // Register writes store the last row and column index, with out-of-range sizes
   // clamped into range.
   always_comb begin
      last_row_in = last_row_ff;
      last_col_in = last_col_ff;
      restart     = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               restart = 1'b1;
               if (csr_write_data == '0) begin
                  last_row_in = '0;
               end else if (csr_write_data > CSR_DATA_W'(ROW_LIMIT)) begin
                  last_row_in = ROW_W'(ROW_LIMIT - 1);
               end else begin
                  last_row_in = ROW_W'(csr_write_data - CSR_DATA_W'(1));
               end
            end
            CSR_COL_COUNT: begin
               restart = 1'b1;
               if (csr_write_data == '0) begin
                  last_col_in = '0;
               end else if (csr_write_data > CSR_DATA_W'(COL_DEPTH)) begin
                  last_col_in = COL_W'(COL_DEPTH - 1);
               end else begin
                  last_col_in = COL_W'(csr_write_data - CSR_DATA_W'(1));
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline moves together; it stops only when a finished grid result
   // cannot enter the full output register.
   assign advance       = !stall;
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;

   // Position of the next cell to arrive. It also addresses the row memory reads.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == last_row_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      addr_b  = col_ff + COL_W'(1);
      ctrl_in = '{row_zero: (row_ff == '0),
                  odd_row:  row_ff[0],
                  right_in: (col_ff != last_col_ff),
                  last_row: (row_ff == last_row_ff),
                  last_col: (col_ff == last_col_ff),
                  col:      col_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         last_row_ff <= '0;
         last_col_ff <= '0;
         s2_valid_ff <= 1'b0;
         held_ff     <= EDGE_PATH;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         last_row_ff <= last_row_in;
         last_col_ff <= last_col_in;
         if (advance) begin
            s2_valid_ff <= accept;
         end
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_value_ff <= req_bus.cell_value;
         s2_ctrl_ff  <= ctrl_in;
      end
   end

   // In even rows the upper-left neighbor is the entry that the previous cell read
   // before overwriting it. Each row starts with an out-of-grid left neighbor.
   always_comb begin
      held_in = held_ff;
      if (restart) begin
         held_in = EDGE_PATH;
      end else if (advance && s2_valid_ff) begin
         if (s2_ctrl_ff.last_col) begin
            held_in = EDGE_PATH;
         end else if (!s2_ctrl_ff.odd_row && !s2_ctrl_ff.row_zero) begin
            held_in = above_a;
         end
      end
   end

   hgpc_row_mem u_row_mem (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (col_ff),
      .rd_addr_b (addr_b),
      .rd_data_a (above_a),
      .rd_data_b (above_b),
      .wr_en     (advance && s2_valid_ff),
      .wr_addr   (s2_ctrl_ff.col),
      .wr_data   (cell_result)
   );

   hgpc_cell_calc u_cell_calc (
      .value   (s2_value_ff),
      .ctrl    (s2_ctrl_ff),
      .above_a (above_a),
      .above_b (above_b),
      .held    (held_ff),
      .result  (cell_result)
   );

   always_comb begin
      fold_in = '{last_row: s2_ctrl_ff.last_row,
                  last_col: s2_ctrl_ff.last_col,
                  path:     cell_result};
   end

   hgpc_best_fold u_best_fold (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .advance    (advance),
      .in_valid   (s2_valid_ff),
      .in_data    (fold_in),
      .rsp_ready  (rsp_bus.ready),
      .stall      (stall),
      .rsp_valid  (rsp_valid),
      .best_sum   (best_sum),
      .path_count (path_count)
   );

   assign rsp_bus.valid      = rsp_valid;
   assign rsp_bus.best_sum   = best_sum;
   assign rsp_bus.path_count = path_count;

   // The column position never runs past the last column in use.
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col_ff)
      else $error("column position beyond the last column");

   // Finishing a row leaves an out-of-grid left neighbor for the next row.
   a_held_row_start: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff && s2_ctrl_ff.last_col) |=> (held_ff == EDGE_PATH))
      else $error("left neighbor not cleared at row end");

   // Every last row has at least one cell, so a result always counts a path.
   a_result_has_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (path_count != '0))
      else $error("result with zero paths");

endmodule

`default_nettype wire
